/* rtl/core/lkc_pkg.sv */
// Shared constants, types and codes for the LRU key cache.
package lkc_pkg;

  localparam int CAPACITY   = 16;
  localparam int ID_WIDTH   = 16;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int RANK_W     = $clog2(CAPACITY);
  localparam int OCC_W      = $clog2(CAPACITY + 1);
  localparam int BLOCK_ID_W = 16;
  localparam int FACE_W     = 7;
  localparam int TILE_W     = 11;
  localparam int LIMIT_W    = 5;
  localparam int OUT_SLOT_W = 4;

  localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = LIMIT_W'(16);

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_EVICT  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic do_hit;
    logic do_evict;
    logic do_insert;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic hit;
    logic need_evict;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/lkc_if.sv */
// Channel interfaces for the LRU key cache: lookup keys, result rows and the limit register.
interface lkc_in_if;
  import lkc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [BLOCK_ID_W-1:0]        block_id;
  logic signed [FACE_W-1:0]     face_index;
  logic [TILE_W-1:0]            tile_size;

  modport source (output valid, block_id, face_index, tile_size, input ready);
  modport sink (input valid, block_id, face_index, tile_size, output ready);
endinterface

interface lkc_out_if;
  import lkc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic                         hit;
  logic [OUT_SLOT_W-1:0]        slot;
  logic [BLOCK_ID_W-1:0]        victim_block_id;
  logic signed [FACE_W-1:0]     victim_face_index;
  logic [TILE_W-1:0]            victim_tile_size;
  logic                         last;

  modport source (output valid, kind, hit, slot, victim_block_id, victim_face_index,
                  victim_tile_size, last, input ready);
  modport sink (input valid, kind, hit, slot, victim_block_id, victim_face_index,
                victim_tile_size, last, output ready);
endinterface

interface lkc_cfg_if;
  import lkc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LIMIT_W-1:0]   max_entries;

  modport source (output valid, max_entries, input ready);
  modport sink (input valid, max_entries, output ready);
endinterface

/* rtl/core/lkc_ctrl.sv */
// Controller state machine that sequences lookup, eviction and insertion.
module lkc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  lkc_pkg::sts_t sts,
  output lkc_pkg::cmd_t cmd
);
  import lkc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.out_free && (sts.hit || !sts.need_evict)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_rdy = 1'b1;
      end
      ST_CMP: begin
        cmd.do_hit    = sts.out_free && sts.hit;
        cmd.do_evict  = sts.out_free && !sts.hit && sts.need_evict;
        cmd.do_insert = sts.out_free && !sts.hit && !sts.need_evict;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/lkc_dpath.sv */
// Datapath of the LRU key cache: entry table, recency ranks, limit register and result register.
module lkc_dpath (
  input  logic          clk,
  input  logic          rst_n,
  lkc_in_if.sink        in_ch,
  lkc_out_if.source     out_ch,
  lkc_cfg_if.sink       cfg_ch,
  input  lkc_pkg::cmd_t cmd,
  output lkc_pkg::sts_t sts
);
  import lkc_pkg::*;

  logic [CAPACITY-1:0]   valid_r;
  logic [CAPACITY-1:0]   valid_nxt;
  logic [RANK_W-1:0]     rank_r [CAPACITY];
  logic [RANK_W-1:0]     rank_nxt [CAPACITY];
  logic [ID_WIDTH-1:0]   key_id_r [CAPACITY];
  logic [FACE_W-1:0]     key_face_r [CAPACITY];
  logic [TILE_W-1:0]     key_tile_r [CAPACITY];
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;
  logic [LIMIT_W-1:0]    max_r;

  logic [ID_WIDTH-1:0]   cur_id_r;
  logic [FACE_W-1:0]     cur_face_r;
  logic [TILE_W-1:0]     cur_tile_r;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_kind_r;
  logic                  out_hit_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [BLOCK_ID_W-1:0] out_vid_r;
  logic [FACE_W-1:0]     out_vface_r;
  logic [TILE_W-1:0]     out_vtile_r;
  logic                  out_last_r;

  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   victim_vec;
  logic [SLOT_W-1:0]     hit_idx;
  logic [SLOT_W-1:0]     victim_idx;
  logic [SLOT_W-1:0]     free_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [OCC_W-1:0]      limit;
  logic                  out_free;
  logic                  row_load;
  logic                  in_acc;

  assign in_ch.ready  = cmd.in_rdy;
  assign in_acc       = in_ch.valid && cmd.in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign row_load     = cmd.do_hit || cmd.do_evict || cmd.do_insert;

  always_comb begin
    if (max_r == '0) begin
      limit = OCC_W'(1);
    end else if (max_r > CAPACITY) begin
      limit = OCC_W'(CAPACITY);
    end else begin
      limit = OCC_W'(max_r);
    end
  end

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = valid_r[i] && (key_id_r[i] == cur_id_r) &&
                   (key_face_r[i] == cur_face_r) && (key_tile_r[i] == cur_tile_r);
      victim_vec[i] = valid_r[i] && (OCC_W'(rank_r[i]) == (occ_r - OCC_W'(1)));
      if (hit_vec[i]) begin
        hit_idx = hit_idx | SLOT_W'(i);
      end
      if (victim_vec[i]) begin
        victim_idx = victim_idx | SLOT_W'(i);
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_rank = rank_r[hit_idx];

  assign sts.in_valid   = in_ch.valid;
  assign sts.hit        = |hit_vec;
  assign sts.need_evict = occ_r >= limit;
  assign sts.out_free   = out_free;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int j = 0; j < CAPACITY; j++) begin
      rank_nxt[j] = rank_r[j];
    end
    if (cmd.do_hit) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_r[j] && (rank_r[j] < hit_rank)) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
      rank_nxt[hit_idx] = '0;
    end else if (cmd.do_evict) begin
      valid_nxt[victim_idx] = 1'b0;
      occ_nxt = occ_r - OCC_W'(1);
    end else if (cmd.do_insert) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_r[j]) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
      valid_nxt[free_idx] = 1'b1;
      rank_nxt[free_idx]  = '0;
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (row_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      max_r       <= MAX_ENTRIES_RESET;
      out_valid_r <= 1'b0;
      for (int j = 0; j < CAPACITY; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < CAPACITY; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
      if (cfg_ch.valid) begin
        max_r <= cfg_ch.max_entries;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_id_r   <= in_ch.block_id[ID_WIDTH-1:0];
      cur_face_r <= in_ch.face_index;
      cur_tile_r <= in_ch.tile_size;
    end
    if (cmd.do_insert) begin
      key_id_r[free_idx]   <= cur_id_r;
      key_face_r[free_idx] <= cur_face_r;
      key_tile_r[free_idx] <= cur_tile_r;
    end
    if (cmd.do_evict) begin
      out_kind_r  <= KIND_EVICT;
      out_hit_r   <= 1'b0;
      out_slot_r  <= OUT_SLOT_W'(victim_idx);
      out_vid_r   <= BLOCK_ID_W'(key_id_r[victim_idx]);
      out_vface_r <= key_face_r[victim_idx];
      out_vtile_r <= key_tile_r[victim_idx];
      out_last_r  <= 1'b0;
    end else if (cmd.do_hit || cmd.do_insert) begin
      out_kind_r  <= KIND_ANSWER;
      out_hit_r   <= cmd.do_hit;
      out_slot_r  <= cmd.do_hit ? OUT_SLOT_W'(hit_idx) : OUT_SLOT_W'(free_idx);
      out_vid_r   <= '0;
      out_vface_r <= '0;
      out_vtile_r <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind              = out_kind_r;
  assign out_ch.hit               = out_hit_r;
  assign out_ch.slot              = out_slot_r;
  assign out_ch.victim_block_id   = out_vid_r;
  assign out_ch.victim_face_index = $signed(out_vface_r);
  assign out_ch.victim_tile_size  = out_vtile_r;
  assign out_ch.last              = out_last_r;

endmodule

/* rtl/core/lru_key_cache_unit.sv */
// Top level of the LRU key cache: controller and datapath joined by command and status.
//
// A key beat on the in_ channel (block_id, face_index, tile_size) is looked up in a
// 16-entry fully associative table. A hit makes the entry most recent and yields one
// answer row. A miss first evicts least recent entries, one eviction row each, while
// the occupancy is at least the limit, then inserts the key into the lowest free slot
// and yields the answer row. The answer row is always the final row and has last set.
// The cfg_ channel writes the limit register (zero acts as one, values above the
// table size act as the table size); the user must write it only while the block
// is idle, as the block itself does not enforce this. A key is compared in the cycle
// after its beat. Each eviction and the final hit or insert is a single compare-and-update
// step of the table, and each row is loaded into the result register; no new key beat
// is taken until the final row of the previous item has been loaded.
// The result register holds a row while out_ready is low; the table stalls then,
// but the next key beat is taken while the final row of the previous item waits.
// Reset empties the table, clears all ranks and sets the limit to 16; no sweep follows.
module lru_key_cache_unit (
  input  logic      clk,
  input  logic      rst_n,
  lkc_in_if.sink    in_ch,
  lkc_out_if.source out_ch,
  lkc_cfg_if.sink   cfg_ch
);
  import lkc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  lkc_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

/* bench/lru_key_cache_unit_test.sv */
// Self-checking testbench for the LRU key cache: directed table, random phases, LRU predictor.
module lru_key_cache_unit_test;
  import lkc_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int POOL_SIZE       = 24;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 20;
  localparam int PRINT_CAP       = 40;

  typedef enum logic {
    ROW_KEY,
    ROW_LIMIT
  } row_op_t;

  typedef struct packed {
    logic [BLOCK_ID_W-1:0] id;
    logic [FACE_W-1:0]     face;
    logic [TILE_W-1:0]     tile;
  } key_t;

  typedef struct {
    logic                     kind;
    logic                     hit;
    logic [OUT_SLOT_W-1:0]    slot;
    logic [BLOCK_ID_W-1:0]    vid;
    logic signed [FACE_W-1:0] vface;
    logic [TILE_W-1:0]        vtile;
    logic                     last;
  } result_row_t;

  typedef struct {
    row_op_t               op;
    key_t                  key;
    logic [LIMIT_W-1:0]    limit;
    logic                  typed;
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  calm;
  logic                  cur_typed;
  logic                  cur_hit;
  logic [OUT_SLOT_W-1:0] cur_slot;
  int                    mismatches;
  int                    quiet_cycles;

  result_row_t expected_rows[$];
  logic        tag_valid[CAPACITY];
  key_t        tags[CAPACITY];
  int          age[CAPACITY];
  int          occupancy;
  int          limit_reg;

  // Face -1 is written as its raw pattern 7'h7F and face -64 as 7'h40.
  stim_row_t directed_rows[18] = '{
    '{ROW_KEY,   '{16'h0000, 7'h7F, 11'd1},    5'd0,  1'b1, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'hFFFF, 7'h3F, 11'd1024}, 5'd0,  1'b1, 1'b0, 4'd1},
    '{ROW_KEY,   '{16'h0000, 7'h7F, 11'd1},    5'd0,  1'b1, 1'b1, 4'd0},
    '{ROW_KEY,   '{16'hFFFF, 7'h40, 11'd2047}, 5'd0,  1'b1, 1'b0, 4'd2},
    '{ROW_KEY,   '{16'h0001, 7'h00, 11'd0},    5'd0,  1'b1, 1'b0, 4'd3},
    '{ROW_KEY,   '{16'h0000, 7'h7F, 11'd2},    5'd0,  1'b1, 1'b0, 4'd4},
    '{ROW_KEY,   '{16'h0000, 7'h00, 11'd1},    5'd0,  1'b1, 1'b0, 4'd5},
    '{ROW_KEY,   '{16'hFFFF, 7'h3F, 11'd1024}, 5'd0,  1'b1, 1'b1, 4'd1},
    '{ROW_LIMIT, '0,                           5'd2,  1'b0, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'h0001, 7'h00, 11'd0},    5'd0,  1'b1, 1'b1, 4'd3},
    '{ROW_KEY,   '{16'h1234, 7'h15, 11'd64},   5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LIMIT, '0,                           5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'h1234, 7'h15, 11'd64},   5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'h5555, 7'h2A, 11'd512},  5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LIMIT, '0,                           5'd31, 1'b0, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'hAAAA, 7'h55, 11'd1023}, 5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_KEY,   '{16'h5555, 7'h2A, 11'd512},  5'd0,  1'b0, 1'b0, 4'd0},
    '{ROW_LIMIT, '0,                           5'd16, 1'b0, 1'b0, 4'd0}
  };

  lkc_in_if  in_ch();
  lkc_out_if out_ch();
  lkc_cfg_if cfg_ch();

  lru_key_cache_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    end
  endtask

  function automatic void queue_row(result_row_t r);
    expected_rows = {expected_rows, r};
  endfunction

  function automatic void push_answer(logic hit, int slot);
    result_row_t r;
    r.kind  = KIND_ANSWER;
    r.hit   = hit;
    r.slot  = OUT_SLOT_W'(slot);
    r.vid   = '0;
    r.vface = '0;
    r.vtile = '0;
    r.last  = 1'b1;
    if (cur_typed) begin
      r.hit  = cur_hit;
      r.slot = cur_slot;
    end
    queue_row(r);
  endfunction

  function automatic void predict_lookup(key_t k);
    int          i;
    int          j;
    int          lim;
    int          hit_age;
    int          victim;
    int          free_slot;
    result_row_t r;
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > CAPACITY) lim = CAPACITY;
    for (i = 0; i < CAPACITY; i++) begin
      if (tag_valid[i] && tags[i] == k) begin
        hit_age = age[i];
        for (j = 0; j < CAPACITY; j++) begin
          if (tag_valid[j] && age[j] < hit_age) age[j]++;
        end
        age[i] = 0;
        push_answer(1'b1, i);
        return;
      end
    end
    while (occupancy >= lim && occupancy > 0) begin
      victim = -1;
      for (i = 0; i < CAPACITY; i++) begin
        if (tag_valid[i] && (victim < 0 || age[i] > age[victim])) victim = i;
      end
      if (victim < 0) begin
        occupancy = 0;
        break;
      end
      tag_valid[victim] = 1'b0;
      occupancy--;
      r.kind  = KIND_EVICT;
      r.hit   = 1'b0;
      r.slot  = OUT_SLOT_W'(victim);
      r.vid   = tags[victim].id;
      r.vface = tags[victim].face;
      r.vtile = tags[victim].tile;
      r.last  = 1'b0;
      queue_row(r);
    end
    free_slot = -1;
    for (i = 0; i < CAPACITY; i++) begin
      if (!tag_valid[i] && free_slot < 0) free_slot = i;
    end
    if (free_slot < 0) free_slot = 0;
    for (i = 0; i < CAPACITY; i++) begin
      if (tag_valid[i]) age[i]++;
    end
    tag_valid[free_slot] = 1'b1;
    tags[free_slot]      = k;
    age[free_slot]       = 0;
    occupancy++;
    push_answer(1'b0, free_slot);
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.id   = BLOCK_ID_W'($urandom);
    k.face = FACE_W'($urandom);
    k.tile = TILE_W'($urandom);
    return k;
  endfunction

  always @(posedge clk) begin
    result_row_t want;
    int          i;
    if (!rst_n) begin
      for (i = 0; i < CAPACITY; i++) begin
        tag_valid[i] = 1'b0;
        tags[i]      = '0;
        age[i]       = 0;
      end
      occupancy    = 0;
      limit_reg    = MAX_ENTRIES_RESET;
      quiet_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_lookup('{in_ch.block_id, in_ch.face_index, in_ch.tile_size});
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_reg = cfg_ch.max_entries;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, slot %0d", out_ch.slot));
        end else begin
          want = expected_rows.pop_front();
          check_field("kind", out_ch.kind, want.kind);
          check_field("hit", out_ch.hit, want.hit);
          check_field("slot", out_ch.slot, want.slot);
          check_field("victim_block_id", out_ch.victim_block_id, want.vid);
          check_field("victim_face_index", out_ch.victim_face_index, want.vface);
          check_field("victim_tile_size", out_ch.victim_tile_size, want.vtile);
          check_field("last", out_ch.last, want.last);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  task automatic drive_key(key_t k, logic typed, logic hit, logic [OUT_SLOT_W-1:0] slot);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.block_id   <= k.id;
    in_ch.face_index <= k.face;
    in_ch.tile_size  <= k.tile;
    cur_typed        <= typed;
    cur_hit          <= hit;
    cur_slot         <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_rows.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_entries <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    key_t               key_pool[POOL_SIZE];
    logic [LIMIT_W-1:0] phase_limit[PHASES];
    key_t               k;
    int                 p;
    int                 n;
    rst_n              = 1'b0;
    calm               = 1'b0;
    mismatches         = 0;
    in_ch.valid        = 1'b0;
    in_ch.block_id     = '0;
    in_ch.face_index   = '0;
    in_ch.tile_size    = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_entries = '0;
    cur_typed          = 1'b0;
    cur_hit            = 1'b0;
    cur_slot           = '0;
    phase_limit = '{5'd16, 5'd4, 5'd31, 5'd1, LIMIT_W'($urandom_range(2, 15)), 5'd0};
    for (p = 0; p < POOL_SIZE; p++) key_pool[p] = random_key();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == ROW_KEY) begin
        drive_key(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].hit,
                  directed_rows[r].slot);
      end else begin
        set_limit(directed_rows[r].limit);
      end
    end

    // Most beats reuse a small pool of keys so that hits and evictions mix.
    for (p = 0; p < PHASES; p++) begin
      set_limit(phase_limit[p]);
      calm <= (p == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(99) < 65) begin
          k = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
          k = random_key();
        end
        drive_key(k, 1'b0, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
